FILE: hdl/factm_pkg.sv
`default_nettype none

package factm_pkg;

  // table sizes
  localparam int NUM_FEATURES = 4096;
  localparam int MAX_FACTORS  = 16;

  // field widths
  localparam int FEAT_W = 12;
  localparam int FACT_W = 4;
  localparam int WORD_W = 32;
  localparam int PRED_W = 64;

  // field types
  typedef logic [1:0]               cmd_t;
  typedef logic [FEAT_W-1:0]        feat_idx_t;
  typedef logic [FACT_W-1:0]        fact_idx_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PRED_W-1:0] pred_t;
  typedef logic [1:0]               cfg_idx_t;
  typedef logic [4:0]               fac_cnt_t;

  // command codes
  localparam cmd_t CMD_LIN_WR  = 2'd0;
  localparam cmd_t CMD_FAC_WR  = 2'd1;
  localparam cmd_t CMD_FEATURE = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t REG_BIAS        = 2'd0;
  localparam cfg_idx_t REG_USE_BIAS    = 2'd1;
  localparam cfg_idx_t REG_ACT_FACTORS = 2'd2;

  // register reset values
  localparam fac_cnt_t ACT_FACTORS_RST = 5'd16;

  // largest magnitude whose square still fits a signed 64-bit value
  localparam logic [47:0] SQRT_LIM = 48'd3037000499;

endpackage

`default_nettype wire

FILE: hdl/factm_ram.sv
`default_nettype none

module factm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/factorization_machine_predict_core.sv
`default_nettype none

// channel   handshake            payload
// input     start / busy         in_command, in_feature_index, in_factor_index, in_value, in_last
// result    out_valid (strobe)   out_prediction, out_saturated
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// weight writes complete in the accept cycle and never raise busy.
// a feature item keeps busy high until its products and squares are summed (nf = factors
// in use): one 33x33 multiplier serves the factor products and the squares in turn.
// the item marked last adds a final summation over the nf factor sums, and out_valid
// rises in the same cycle as busy falls.
// rst_n is synchronous: config returns to bias 0, bias on, 16 factors; sums are zeroed.
// out_valid is high for one cycle per result; the receiver cannot stall it.

module factorization_machine_predict_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  factm_pkg::cmd_t      in_command,
  input  factm_pkg::feat_idx_t in_feature_index,
  input  factm_pkg::fact_idx_t in_factor_index,
  input  factm_pkg::word_t     in_value,
  input  logic                 in_last,
  output logic                 out_valid,
  output factm_pkg::pred_t     out_prediction,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  factm_pkg::cfg_idx_t  cfg_index,
  input  factm_pkg::word_t     cfg_data
);

  import factm_pkg::*;

  localparam int CNT_W = FACT_W + 1;
  localparam int ACC_W = 72;
  localparam int FAC_ADDR_W = FEAT_W + FACT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FEAT = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // control
  logic [1:0]       state_r, state_nxt;
  logic             accept, feat_ok, fac_ok;
  logic [CNT_W-1:0] nf;

  // configuration
  word_t    bias_r;
  logic     use_bias_r;
  fac_cnt_t act_fac_r;

  // current item
  feat_idx_t        fi_r, fi_nxt;
  word_t            x_r;
  logic             last_r;
  logic             lin_pend_r, lin_pend_nxt;
  logic [CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0] gcnt_r;
  logic             issue, issue_lin, feed, feat_done, fin_done;

  // weight tables
  logic [WORD_W-1:0] lin_rdata, fac_rdata;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // pipeline stages
  logic signed [63:0] prod_r;
  logic               prod_v_r, prod_lin_r;
  fact_idx_t          prod_f_r;
  logic [31:0]        m_r;
  logic               m_over_r, m_v_r;
  fact_idx_t          m_f_r;
  logic [63:0]        sq_r;
  logic               sq_v_r;
  fact_idx_t          sq_f_r;

  // accumulators
  logic signed [63:0]      lin_sum_r;
  logic signed [47:0]      fsum_r [MAX_FACTORS];
  logic signed [63:0]      ssum_r [MAX_FACTORS];
  logic                    clip_r;
  logic signed [ACC_W-1:0] acc_r;

  // datapath nets
  logic signed [47:0] t48, fs_cur, abs_src;
  logic [47:0]        abs_val;
  fact_idx_t          fs_idx;
  logic signed [64:0] lsum;
  logic               lsum_ovf;
  logic signed [48:0] fadd;
  logic               fadd_ovf;
  logic signed [63:0] ss_cur;
  logic signed [64:0] sadd;
  logic               sadd_ovf;
  logic signed [64:0] diff;
  logic signed [ACC_W-1:0] acc_init, acc_add;
  logic               fits;

  // output registers
  logic  out_valid_r, out_sat_r;
  pred_t out_pred_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign feat_ok = ({1'b0, in_feature_index} < (FEAT_W + 1)'(NUM_FEATURES));
  assign fac_ok  = ({1'b0, in_factor_index} < (FACT_W + 1)'(MAX_FACTORS));

  // factors in use, clipped to the table
  assign nf = (act_fac_r > 5'(MAX_FACTORS)) ? CNT_W'(MAX_FACTORS) : CNT_W'(act_fac_r);

  // issue order: linear weight first, then factors in turn, when the multiplier is free
  assign issue     = (state_r == ST_FEAT) & ~m_v_r & (lin_pend_r | (fcnt_r < nf));
  assign issue_lin = issue & lin_pend_r;
  assign feed      = (state_r == ST_FIN) & (gcnt_r < nf);
  assign feat_done = ~lin_pend_r & ~(fcnt_r < nf) & ~prod_v_r & ~m_v_r & ~sq_v_r;
  assign fin_done  = ~(gcnt_r < nf) & ~m_v_r & ~sq_v_r;

  // item capture and read-ahead address
  always_comb begin
    fi_nxt       = fi_r;
    lin_pend_nxt = lin_pend_r;
    fcnt_nxt     = fcnt_r;
    if (accept && in_command == CMD_FEATURE) begin
      fi_nxt       = in_feature_index;
      lin_pend_nxt = feat_ok;
      fcnt_nxt     = feat_ok ? '0 : nf;
    end else if (issue_lin) begin
      lin_pend_nxt = 1'b0;
    end else if (issue) begin
      fcnt_nxt = fcnt_r + CNT_W'(1);
    end
  end

  // weight tables
  factm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_FEATURES)
  ) u_lin_ram (
    .clk   (clk),
    .we    (accept & (in_command == CMD_LIN_WR) & feat_ok),
    .waddr (in_feature_index),
    .wdata (in_value),
    .raddr (fi_nxt),
    .rdata (lin_rdata)
  );

  factm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_FEATURES * MAX_FACTORS)
  ) u_fac_ram (
    .clk   (clk),
    .we    (accept & (in_command == CMD_FAC_WR) & feat_ok & fac_ok),
    .waddr (FAC_ADDR_W'({in_feature_index, in_factor_index})),
    .wdata (in_value),
    .raddr (FAC_ADDR_W'({fi_nxt, fcnt_nxt[FACT_W-1:0]})),
    .rdata (fac_rdata)
  );

  // shared multiplier: square when the square stage holds a value, else weight times value
  always_comb begin
    if (m_v_r) begin
      mul_a = $signed({1'b0, m_r});
      mul_b = $signed({1'b0, m_r});
    end else if (issue_lin) begin
      mul_a = $signed({lin_rdata[31], lin_rdata});
      mul_b = $signed({x_r[31], x_r});
    end else begin
      mul_a = $signed({fac_rdata[31], fac_rdata});
      mul_b = $signed({x_r[31], x_r});
    end
  end
  assign mul_p = mul_a * mul_b;

  // product stage: floor shift by 16, running sums
  assign t48    = prod_r[63:16];
  assign fs_idx = (state_r == ST_FIN) ? gcnt_r[FACT_W-1:0] : prod_f_r;
  assign fs_cur = fsum_r[fs_idx];

  assign lsum     = {lin_sum_r[63], lin_sum_r} + {prod_r[63], prod_r};
  assign lsum_ovf = lsum[64] ^ lsum[63];
  assign fadd     = {fs_cur[47], fs_cur} + {t48[47], t48};
  assign fadd_ovf = fadd[48] ^ fadd[47];

  // magnitude for the square, from the product or a finished factor sum
  assign abs_src = (state_r == ST_FIN) ? fs_cur : t48;
  assign abs_val = abs_src[47] ? (48'd0 - $unsigned(abs_src)) : $unsigned(abs_src);

  // square-sum stage and final half-difference
  assign ss_cur   = ssum_r[sq_f_r];
  assign sadd     = {ss_cur[63], ss_cur} + {sq_r[63], sq_r};
  assign sadd_ovf = sadd[64] ^ sadd[63];
  assign diff     = {sq_r[63], sq_r} - {ss_cur[63], ss_cur};
  assign acc_add  = acc_r + {{(ACC_W - 64){diff[64]}}, diff[64:1]};

  // exact start value of the final sum
  assign acc_init = (use_bias_r ? {{(ACC_W - 48){bias_r[31]}}, bias_r, 16'b0} : '0)
                  + {{(ACC_W - 64){lin_sum_r[63]}}, lin_sum_r};
  assign fits     = (acc_r[ACC_W-1:63] == '0) || (acc_r[ACC_W-1:63] == '1);

  // state sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_FEATURE) begin
          state_nxt = ST_FEAT;
        end
      end
      ST_FEAT: begin
        if (feat_done) begin
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (fin_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bias_r      <= '0;
      use_bias_r  <= 1'b1;
      act_fac_r   <= ACT_FACTORS_RST;
      lin_pend_r  <= 1'b0;
      fcnt_r      <= '0;
      gcnt_r      <= '0;
      prod_v_r    <= 1'b0;
      m_v_r       <= 1'b0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lin_pend_r <= lin_pend_nxt;
      fcnt_r     <= fcnt_nxt;

      // register transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BIAS:        bias_r     <= cfg_data;
          REG_USE_BIAS:    use_bias_r <= cfg_data[0];
          REG_ACT_FACTORS: act_fac_r  <= cfg_data[4:0];
          default: ;
        endcase
      end

      // finalization counter
      if (state_r == ST_FEAT && feat_done) begin
        gcnt_r <= '0;
      end else if (feed) begin
        gcnt_r <= gcnt_r + CNT_W'(1);
      end

      prod_v_r    <= issue;
      m_v_r       <= feed | (prod_v_r & ~prod_lin_r & (state_r == ST_FEAT));
      sq_v_r      <= m_v_r;
      out_valid_r <= (state_r == ST_FIN) & fin_done;
    end
  end

  // payload and pipeline data
  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_FEATURE) begin
      x_r    <= in_value;
      last_r <= in_last;
    end
    fi_r <= fi_nxt;

    if (issue) begin
      prod_r     <= $signed(mul_p[63:0]);
      prod_lin_r <= issue_lin;
      prod_f_r   <= fcnt_r[FACT_W-1:0];
    end

    m_r      <= abs_val[31:0];
    m_over_r <= (abs_val > SQRT_LIM);
    m_f_r    <= feed ? gcnt_r[FACT_W-1:0] : prod_f_r;

    sq_r   <= m_over_r ? 64'h7FFF_FFFF_FFFF_FFFF : mul_p[63:0];
    sq_f_r <= m_f_r;

    if (state_r == ST_FIN && fin_done) begin
      out_pred_r <= fits ? acc_r[63:0] : (acc_r[ACC_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}});
      out_sat_r  <= clip_r | ~fits;
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == ST_FIN && fin_done)) begin
      lin_sum_r <= '0;
      clip_r    <= 1'b0;
      for (int i = 0; i < MAX_FACTORS; i++) begin
        fsum_r[i] <= '0;
        ssum_r[i] <= '0;
      end
    end else begin
      // linear and factor sums from the product stage
      if (prod_v_r && state_r == ST_FEAT) begin
        if (prod_lin_r) begin
          lin_sum_r <= lsum_ovf ? (lsum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                                : lsum[63:0];
        end else begin
          fsum_r[prod_f_r] <= fadd_ovf ? (fadd[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                                       : fadd[47:0];
        end
      end

      // square sums
      if (sq_v_r && state_r == ST_FEAT) begin
        ssum_r[sq_f_r] <= sadd_ovf ? (sadd[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                                   : sadd[63:0];
      end

      // sticky clip over the object
      if ((prod_v_r && state_r == ST_FEAT && (prod_lin_r ? lsum_ovf : fadd_ovf))
          || (m_v_r && m_over_r)
          || (sq_v_r && state_r == ST_FEAT && sadd_ovf)) begin
        clip_r <= 1'b1;
      end
    end
  end

  // final sum
  always_ff @(posedge clk) begin
    if (state_r == ST_FEAT && feat_done) begin
      acc_r <= acc_init;
    end else if (sq_v_r && state_r == ST_FIN) begin
      acc_r <= acc_add;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire
